### rtl/core/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types, codes and helpers for the convex polygon point test.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;

    // dropped axis of the plane normal
    typedef enum logic [1:0] {
        AXIS_Z = 2'd0,
        AXIS_X = 2'd1,
        AXIS_Y = 2'd2
    } axis_t;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
    } uv_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
        logic signed [COORD_W-1:0] normal_z;
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_z;
        logic                      last_vertex;
    } vtx_t;

    // per-item control carried down the pipeline
    typedef struct packed {
        logic first;
        logic last;
    } tag_t;

    // operand pairs for the step edge (prev -> cur) and the closing edge (cur -> first)
    typedef struct packed {
        logic signed [DIFF_W-1:0] step_au;
        logic signed [DIFF_W-1:0] step_ev;
        logic signed [DIFF_W-1:0] step_av;
        logic signed [DIFF_W-1:0] step_eu;
        logic signed [DIFF_W-1:0] close_au;
        logic signed [DIFF_W-1:0] close_ev;
        logic signed [DIFF_W-1:0] close_av;
        logic signed [DIFF_W-1:0] close_eu;
    } diff_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] step_p0;
        logic signed [PROD_W-1:0] step_p1;
        logic signed [PROD_W-1:0] close_p0;
        logic signed [PROD_W-1:0] close_p1;
    } prod_t;

    function automatic logic [COORD_W-1:0] mag(input logic signed [COORD_W-1:0] a);
        mag = a[COORD_W-1] ? COORD_W'(-a) : COORD_W'(a);
    endfunction

    function automatic logic signed [DIFF_W-1:0] sub_ext(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        sub_ext = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    endfunction

    function automatic uv_t project(
        input axis_t                     ax,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic signed [COORD_W-1:0] z
    );
        uv_t r;
        case (ax)
            AXIS_Y:  begin r.u = x; r.v = z; end
            AXIS_X:  begin r.u = y; r.v = z; end
            default: begin r.u = x; r.v = y; end
        endcase
        project = r;
    endfunction

    function automatic sign_t sign_of(
        input logic signed [PROD_W-1:0] p0,
        input logic signed [PROD_W-1:0] p1
    );
        logic signed [SUM_W-1:0] s;
        s = $signed({p0[PROD_W-1], p0}) + $signed({p1[PROD_W-1], p1});
        if (s[SUM_W-1])
            sign_of = SIGN_NEG;
        else if (s != '0)
            sign_of = SIGN_POS;
        else
            sign_of = SIGN_ZERO;
    endfunction

    function automatic logic opposite(input sign_t a, input sign_t b);
        opposite = ((a == SIGN_POS) && (b == SIGN_NEG)) ||
                   ((a == SIGN_NEG) && (b == SIGN_POS));
    endfunction

endpackage

### rtl/core/cpt_project.sv
// ----------------------------------------------------------------------------
// cpt_project
// Polygon setup and projection stage: picks the dropped axis, holds the
// projected point and vertices, and forms the edge function differences.
// ----------------------------------------------------------------------------
module cpt_project (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  cpt_pkg::vtx_t vtx,
    output cpt_pkg::diff_t diff_reg,
    output cpt_pkg::tag_t  tag_reg
);
    import cpt_pkg::*;

    logic        busy_reg;
    axis_t       drop_reg;
    uv_t         point_reg;
    uv_t         first_reg;
    uv_t         prev_reg;

    logic        is_first;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] az;
    axis_t       drop_new;
    axis_t       drop_use;
    uv_t         p_use;
    uv_t         cur;
    uv_t         first_use;
    diff_t       diff_next;
    tag_t        tag_next;

    assign is_first = !busy_reg;
    assign ax = mag(vtx.normal_x);
    assign ay = mag(vtx.normal_y);
    assign az = mag(vtx.normal_z);

    // y only if strictly largest, then x, ties fall to z
    always_comb begin
        if ((ay > ax) && (ay > az))
            drop_new = AXIS_Y;
        else if ((ax > ay) && (ax > az))
            drop_new = AXIS_X;
        else
            drop_new = AXIS_Z;
    end

    assign drop_use  = is_first ? drop_new : drop_reg;
    assign p_use     = is_first ? project(drop_new, vtx.point_x, vtx.point_y, vtx.point_z)
                                : point_reg;
    assign cur       = project(drop_use, vtx.vert_x, vtx.vert_y, vtx.vert_z);
    assign first_use = is_first ? cur : first_reg;

    always_comb begin
        diff_next.step_au  = sub_ext(prev_reg.u, p_use.u);
        diff_next.step_ev  = sub_ext(prev_reg.v, cur.v);
        diff_next.step_av  = sub_ext(prev_reg.v, p_use.v);
        diff_next.step_eu  = sub_ext(cur.u, prev_reg.u);
        diff_next.close_au = sub_ext(cur.u, p_use.u);
        diff_next.close_ev = sub_ext(cur.v, first_use.v);
        diff_next.close_av = sub_ext(cur.v, p_use.v);
        diff_next.close_eu = sub_ext(first_use.u, cur.u);
        tag_next.first     = is_first;
        tag_next.last      = vtx.last_vertex;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (en) begin
            busy_reg <= !vtx.last_vertex;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (is_first) begin
                drop_reg  <= drop_new;
                point_reg <= p_use;
                first_reg <= cur;
            end
            prev_reg <= cur;
            diff_reg <= diff_next;
            tag_reg  <= tag_next;
        end
    end

`ifndef SYNTHESIS
    a_last_ends_polygon : assert property (@(posedge aclk) disable iff (!aresetn)
        en && vtx.last_vertex |=> !busy_reg)
        else $error("polygon still open after last vertex");

    a_tag_tracks_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        en |=> (tag_reg.first == !$past(busy_reg)))
        else $error("first flag does not match polygon state");
`endif

endmodule

### rtl/core/cpt_mul.sv
// ----------------------------------------------------------------------------
// cpt_mul
// Product stage: both edge function products for the step edge and for the closing edge, registered.
// ----------------------------------------------------------------------------
module cpt_mul (
    input  logic           aclk,
    input  logic           en,
    input  cpt_pkg::diff_t diff,
    input  cpt_pkg::tag_t  tag_in,
    output cpt_pkg::prod_t prod_reg,
    output cpt_pkg::tag_t  tag_reg
);
    import cpt_pkg::*;

    prod_t prod_next;

    always_comb begin
        prod_next.step_p0  = diff.step_au * diff.step_ev;
        prod_next.step_p1  = diff.step_av * diff.step_eu;
        prod_next.close_p0 = diff.close_au * diff.close_ev;
        prod_next.close_p1 = diff.close_av * diff.close_eu;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            tag_reg  <= tag_in;
        end
    end

endmodule

### rtl/core/cpt_sign.sv
// ----------------------------------------------------------------------------
// cpt_sign
// Sign stage: tracks edge signs across a polygon and holds the verdict in
// the output register.
// ----------------------------------------------------------------------------
module cpt_sign (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           go,
    input  logic           out_take,
    input  cpt_pkg::prod_t prod,
    input  cpt_pkg::tag_t  tag,
    output logic           out_valid_reg,
    output logic           inside_reg
);
    import cpt_pkg::*;

    logic  seen_reg;
    logic  failed_reg;
    sign_t prev_sign_reg;
    sign_t first_sign_reg;

    sign_t s_step;
    sign_t s_close;
    logic  seen_next;
    logic  failed_next;
    sign_t prev_sign_next;
    sign_t first_sign_next;

    assign s_step  = sign_of(prod.step_p0, prod.step_p1);
    assign s_close = sign_of(prod.close_p0, prod.close_p1);

    always_comb begin
        seen_next       = seen_reg;
        failed_next     = failed_reg;
        prev_sign_next  = prev_sign_reg;
        first_sign_next = first_sign_reg;
        if (tag.first) begin
            seen_next       = 1'b0;
            failed_next     = 1'b0;
            prev_sign_next  = SIGN_ZERO;
            first_sign_next = SIGN_ZERO;
        end else begin
            if (!seen_reg) begin
                first_sign_next = s_step;
                seen_next       = 1'b1;
            end else if (opposite(s_step, prev_sign_reg)) begin
                failed_next = 1'b1;
            end
            // a zero dot becomes the remembered sign
            prev_sign_next = s_step;
        end
        // closing edge is checked against the first edge only
        if (tag.last && seen_next && opposite(s_close, first_sign_next))
            failed_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= 1'b0;
            failed_reg     <= 1'b0;
            prev_sign_reg  <= SIGN_ZERO;
            first_sign_reg <= SIGN_ZERO;
            out_valid_reg  <= 1'b0;
        end else begin
            if (go) begin
                seen_reg       <= seen_next;
                failed_reg     <= failed_next;
                prev_sign_reg  <= prev_sign_next;
                first_sign_reg <= first_sign_next;
            end
            if (go && tag.last)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (go && tag.last)
            inside_reg <= !failed_next;
    end

`ifndef SYNTHESIS
    a_first_clears_fail : assert property (@(posedge aclk) disable iff (!aresetn)
        go && tag.first |=> !failed_reg)
        else $error("fail flag not cleared at polygon start");

    a_single_vertex_inside : assert property (@(posedge aclk) disable iff (!aresetn)
        go && tag.first && tag.last |=> out_valid_reg && inside_reg)
        else $error("single vertex polygon not reported inside");
`endif

endmodule

### rtl/core/convex_polygon_point_test.sv
// ----------------------------------------------------------------------------
// convex_polygon_point_test
// Streams polygon vertices and reports whether the query point is inside.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one vertex per transaction. The first transaction of each
//   polygon also supplies the query point and the plane normal; s_tlast marks
//   the final vertex. Point and normal on later vertices are ignored.
//   Master channel: one transaction per polygon, issued for its last vertex,
//   m_tdata[0] = 1 when the point is inside.
// Throughput: one vertex per clock cycle while the output register is not
//   stalled; the product stage has four 17x17 signed multipliers working in parallel.
// Result path: the accepted last vertex passes the difference and product
//   registers, then its result is loaded into the output register.
// Pipeline: input register, projection/difference stage, product stage,
//   sign stage feeding the output register.
// Reset: aresetn low for one cycle empties the pipeline and drops any
//   polygon in progress; the next vertex starts a new polygon.
// Stall: while m_tready is low the result waits in the output register;
//   vertices are still accepted until the next last vertex waits in the sign stage and the pipeline fills behind it.
// ----------------------------------------------------------------------------
module convex_polygon_point_test (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, point_z, normal_x, normal_y, normal_z, vert_x, vert_y, vert_z
    input  logic [143:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // inside_res, zero padding
    output logic [7:0]   m_tdata
);
    import cpt_pkg::*;

    logic   [143:0] in_data_reg;
    logic           in_last_reg;
    logic           v1_reg;
    logic           v2_reg;
    logic           v3_reg;

    vtx_t           vtx;
    diff_t          diff;
    tag_t           tag2;
    prod_t          prod;
    tag_t           tag3;
    logic           out_valid;
    logic           inside_bit;

    logic           s_accept;
    logic           out_free;
    logic           go3;
    logic           ready3;
    logic           en2;
    logic           ready2;
    logic           en1;

    assign vtx.point_x     = in_data_reg[15:0];
    assign vtx.point_y     = in_data_reg[31:16];
    assign vtx.point_z     = in_data_reg[47:32];
    assign vtx.normal_x    = in_data_reg[63:48];
    assign vtx.normal_y    = in_data_reg[79:64];
    assign vtx.normal_z    = in_data_reg[95:80];
    assign vtx.vert_x      = in_data_reg[111:96];
    assign vtx.vert_y      = in_data_reg[127:112];
    assign vtx.vert_z      = in_data_reg[143:128];
    assign vtx.last_vertex = in_last_reg;

    // only a last vertex needs room in the output register
    assign out_free = !out_valid || m_tready;
    assign go3      = v3_reg && (!tag3.last || out_free);
    assign ready3   = !v3_reg || go3;
    assign en2      = v2_reg && ready3;
    assign ready2   = !v2_reg || ready3;
    assign en1      = v1_reg && ready2;
    assign s_tready = !v1_reg || ready2;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (s_accept)
                v1_reg <= 1'b1;
            else if (en1)
                v1_reg <= 1'b0;
            if (en1)
                v2_reg <= 1'b1;
            else if (en2)
                v2_reg <= 1'b0;
            if (en2)
                v3_reg <= 1'b1;
            else if (go3)
                v3_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    cpt_project u_project (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en1),
        .vtx      (vtx),
        .diff_reg (diff),
        .tag_reg  (tag2)
    );

    cpt_mul u_mul (
        .aclk     (aclk),
        .en       (en2),
        .diff     (diff),
        .tag_in   (tag2),
        .prod_reg (prod),
        .tag_reg  (tag3)
    );

    cpt_sign u_sign (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .go            (go3),
        .out_take      (m_tready),
        .prod          (prod),
        .tag           (tag3),
        .out_valid_reg (out_valid),
        .inside_reg    (inside_bit)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {7'd0, inside_bit};

endmodule
